[rtl/dab_pkg.sv]
`default_nettype none

package dab_pkg;

  // Widths of the request and response fields.
  localparam int unsigned REQ_W = 3;
  localparam int unsigned NODE_W = 6;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned ROW_W = 64;

  // Default node capacity.
  localparam int unsigned MAX_NODES_DEF = 64;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_REPORT = 3'd2,
    REQ_INSERT = 3'd3,
    REQ_DELETE = 3'd4,
    REQ_NEIGH  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_UNUSED = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Update command from the allocator to the matrix store.
  typedef struct packed {
    logic              set_bit;
    logic              clr_bit;
    logic              clr_row;
    logic              clr_col;
    logic [NODE_W-1:0] row_idx;
    logic [NODE_W-1:0] col_idx;
  } mat_op_t;

endpackage

`default_nettype wire

[rtl/dab_matrix.sv]
`default_nettype none

module dab_matrix import dab_pkg::*; #(
  parameter int unsigned NodeCap = MAX_NODES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mat_op_t           op_i,
  input  wire logic [NODE_W-1:0] rd_row_i,
  input  wire logic [NODE_W-1:0] rd_col_i,
  output logic      [ROW_W-1:0]  rd_bits_o,
  output logic                   rd_bit_o
);

  localparam int unsigned IdxW = $clog2(NodeCap);
  localparam logic [NODE_W:0] CapLim = (NODE_W + 1)'(NodeCap);

  logic [NodeCap-1:0] rows_q [NodeCap];
  logic [NodeCap-1:0] rows_d [NodeCap];
  logic [NodeCap-1:0] rd_row;
  logic [IdxW-1:0]    op_r;
  logic [IdxW-1:0]    op_c;

  // Reads outside the capacity return zero so nothing undefined leaks out.
  always_comb begin
    if ({1'b0, rd_row_i} < CapLim) begin
      rd_row = rows_q[rd_row_i[IdxW-1:0]];
    end else begin
      rd_row = '0;
    end
    if ({1'b0, rd_col_i} < CapLim) begin
      rd_bit_o = rd_row[rd_col_i[IdxW-1:0]];
    end else begin
      rd_bit_o = 1'b0;
    end
  end

  assign rd_bits_o = ROW_W'(rd_row);

  assign op_r = op_i.row_idx[IdxW-1:0];
  assign op_c = op_i.col_idx[IdxW-1:0];

  always_comb begin
    rows_d = rows_q;
    if (op_i.clr_col) begin
      for (int i = 0; i < NodeCap; i++) begin
        rows_d[i][op_c] = 1'b0;
      end
    end
    if (op_i.clr_row) begin
      rows_d[op_r] = '0;
    end
    if (op_i.set_bit) begin
      rows_d[op_r][op_c] = 1'b1;
    end
    if (op_i.clr_bit) begin
      rows_d[op_r][op_c] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NodeCap; i++) begin
        rows_q[i] <= '0;
      end
    end else begin
      rows_q <= rows_d;
    end
  end

endmodule

`default_nettype wire

[rtl/dab_alloc.sv]
`default_nettype none

module dab_alloc import dab_pkg::*; #(
  parameter int unsigned NodeCap = MAX_NODES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [REQ_W-1:0]  req_type_i,
  input  wire logic [NODE_W-1:0] row_i,
  input  wire logic [NODE_W-1:0] col_i,
  output status_e                status_o,
  output logic      [NODE_W-1:0] new_index_o,
  output logic      [CNT_W-1:0]  total_o,
  output logic      [CNT_W-1:0]  used_o,
  output mat_op_t                op_o
);

  localparam int unsigned IdxW = $clog2(NodeCap);
  localparam int unsigned CntW = $clog2(NodeCap + 1);

  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    free_cnt_q, free_cnt_d;
  logic [NodeCap-1:0] free_map_q, free_map_d;
  logic [IdxW-1:0]    low_free;
  logic [IdxW-1:0]    ins_idx;
  status_e            st;

  // Range is checked before the freed mark; the freed mark is only read
  // for an index below the node count.
  function automatic status_e check_idx(input logic [NODE_W-1:0] k,
                                        input logic [CntW-1:0] cnt,
                                        input logic [NodeCap-1:0] fmap);
    status_e r;
    if ({1'b0, k} >= CNT_W'(cnt)) begin
      r = ST_RANGE;
    end else if (fmap[k[IdxW-1:0]]) begin
      r = ST_UNUSED;
    end else begin
      r = ST_OK;
    end
    return r;
  endfunction

  always_comb begin
    low_free = '0;
    for (int i = NodeCap - 1; i >= 0; i--) begin
      if (free_map_q[i]) begin
        low_free = IdxW'(i);
      end
    end
  end

  always_comb begin
    count_d    = count_q;
    free_cnt_d = free_cnt_q;
    free_map_d = free_map_q;
    st         = ST_OK;
    ins_idx    = '0;
    op_o       = '0;
    if (fire_i) begin
      unique case (req_e'(req_type_i))
        REQ_ADD, REQ_REMOVE, REQ_REPORT: begin
          st = check_idx(row_i, count_q, free_map_q);
          if (st == ST_OK) begin
            st = check_idx(col_i, count_q, free_map_q);
          end
          if (st == ST_OK) begin
            op_o.set_bit = (req_type_i == REQ_ADD);
            op_o.clr_bit = (req_type_i == REQ_REMOVE);
            op_o.row_idx = row_i;
            op_o.col_idx = col_i;
          end
        end
        REQ_INSERT: begin
          if (|free_map_q) begin
            ins_idx              = low_free;
            free_map_d[low_free] = 1'b0;
            free_cnt_d           = free_cnt_q - 1'b1;
          end else if (count_q < CntW'(NodeCap)) begin
            ins_idx      = count_q[IdxW-1:0];
            op_o.clr_row = 1'b1;
            op_o.row_idx = NODE_W'(count_q[IdxW-1:0]);
            count_d      = count_q + 1'b1;
          end else begin
            st = ST_FULL;
          end
        end
        REQ_DELETE: begin
          st = check_idx(row_i, count_q, free_map_q);
          if (st == ST_OK) begin
            op_o.clr_row                = 1'b1;
            op_o.clr_col                = 1'b1;
            op_o.row_idx                = row_i;
            op_o.col_idx                = row_i;
            free_map_d[row_i[IdxW-1:0]] = 1'b1;
            free_cnt_d                  = free_cnt_q + 1'b1;
          end
        end
        REQ_NEIGH: begin
          st = check_idx(row_i, count_q, free_map_q);
        end
        default: begin
        end
      endcase
    end
  end

  assign status_o    = st;
  assign new_index_o = NODE_W'(ins_idx);
  assign total_o     = CNT_W'(count_d);
  assign used_o      = CNT_W'(count_d - free_cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      free_cnt_q <= '0;
      free_map_q <= '0;
    end else begin
      count_q    <= count_d;
      free_cnt_q <= free_cnt_d;
      free_map_q <= free_map_d;
    end
  end

  a_free_cnt_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(free_map_q) == int'(free_cnt_q))
    else $error("free count disagrees with free map");

  a_free_le_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= count_q)
    else $error("more freed indices than allocated");

  a_count_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(NodeCap))
    else $error("node count past capacity");

  a_full_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && st == ST_FULL) |-> (count_q == CntW'(NodeCap) && free_map_q == '0))
    else $error("full reported with room left");

endmodule

`default_nettype wire

[rtl/dynamic_adjacency_bit_matrix.sv]
`default_nettype none

// Channel   Direction  Handshake              Payload
// request   in         req_valid_i/req_ready_o  req_type_i, row_index_i, col_index_i
// response  out        rsp_valid_o/rsp_ready_i  status_o, edge_present_o, new_index_o,
//                                               row_bits_o, total_nodes_o, used_nodes_o
//
// Each request is latched in an input register and, once the response
// register can take it, is resolved against the edge matrix and allocator state
// and written into the response register; one request can be taken every cycle
// while responses are not stalled. The matrix, node count and free map are flops;
// row and column clears and the lowest-free search are combinational.
// Reset clears the whole matrix, the node count and the free map at once.
// A stalled response holds the request in the input register, and the input
// side stops taking transfers until the response register frees up.
module dynamic_adjacency_bit_matrix import dab_pkg::*; #(
  parameter int unsigned MaxNodes = MAX_NODES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire logic [REQ_W-1:0]  req_type_i,
  input  wire logic [NODE_W-1:0] row_index_i,
  input  wire logic [NODE_W-1:0] col_index_i,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_ready_i,
  output logic      [1:0]        status_o,
  output logic                   edge_present_o,
  output logic      [NODE_W-1:0] new_index_o,
  output logic      [ROW_W-1:0]  row_bits_o,
  output logic      [CNT_W-1:0]  total_nodes_o,
  output logic      [CNT_W-1:0]  used_nodes_o
);

  // The matrix is 64 by 64 at most, so capacity is clamped to its size.
  localparam int unsigned NodeCap = (MaxNodes < ROW_W) ? MaxNodes : ROW_W;

  // Input register.
  logic              in_valid_q;
  logic [REQ_W-1:0]  in_req_q;
  logic [NODE_W-1:0] in_row_q;
  logic [NODE_W-1:0] in_col_q;

  // Response register.
  logic              out_valid_q;
  status_e           out_status_q;
  logic              out_edge_q;
  logic [NODE_W-1:0] out_new_q;
  logic [ROW_W-1:0]  out_bits_q;
  logic [CNT_W-1:0]  out_total_q;
  logic [CNT_W-1:0]  out_used_q;

  logic              adv;
  status_e           alc_status;
  logic [NODE_W-1:0] alc_new;
  logic [CNT_W-1:0]  alc_total;
  logic [CNT_W-1:0]  alc_used;
  mat_op_t           mat_op;
  logic [ROW_W-1:0]  mat_bits;
  logic              mat_bit;
  logic              res_ok;

  // The held request moves into the response register whenever that
  // register is empty or is being drained in the same cycle. State is
  // updated on the same edge, so the next request sees the new state.
  assign adv         = in_valid_q && (!out_valid_q || rsp_ready_i);
  assign req_ready_o = !in_valid_q || adv;

  dab_alloc #(
    .NodeCap(NodeCap)
  ) u_alloc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (adv),
    .req_type_i (in_req_q),
    .row_i      (in_row_q),
    .col_i      (in_col_q),
    .status_o   (alc_status),
    .new_index_o(alc_new),
    .total_o    (alc_total),
    .used_o     (alc_used),
    .op_o       (mat_op)
  );

  dab_matrix #(
    .NodeCap(NodeCap)
  ) u_matrix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (mat_op),
    .rd_row_i (in_row_q),
    .rd_col_i (in_col_q),
    .rd_bits_o(mat_bits),
    .rd_bit_o (mat_bit)
  );

  // The edge bit and the row bitmap are only reported by their own
  // request types, and only when the indices passed their checks.
  assign res_ok = (alc_status == ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_ready_o) begin
        in_valid_q <= req_valid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      in_req_q <= req_type_i;
      in_row_q <= row_index_i;
      in_col_q <= col_index_i;
    end
    if (adv) begin
      out_status_q <= alc_status;
      out_edge_q   <= (in_req_q == REQ_REPORT) && res_ok && mat_bit;
      out_new_q    <= alc_new;
      out_bits_q   <= ((in_req_q == REQ_NEIGH) && res_ok) ? mat_bits : '0;
      out_total_q  <= alc_total;
      out_used_q   <= alc_used;
    end
  end

  assign rsp_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign edge_present_o = out_edge_q;
  assign new_index_o    = out_new_q;
  assign row_bits_o     = out_bits_q;
  assign total_nodes_o  = out_total_q;
  assign used_nodes_o   = out_used_q;

  a_held_when_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !rsp_ready_i) |=> (in_valid_q && $stable(in_req_q)))
    else $error("held request lost while response stalled");

  a_no_advance_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !(mat_op.set_bit || mat_op.clr_bit || mat_op.clr_row || mat_op.clr_col))
    else $error("matrix updated without a request");

  a_used_le_total : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_used_q <= out_total_q))
    else $error("used nodes exceed total nodes");

endmodule

`default_nettype wire

[tb/dab_checker.sv]
`default_nettype none

module dab_checker import dab_pkg::*; #(
  parameter int unsigned MaxNodes = MAX_NODES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire logic              req_ready_i,
  input  wire logic [REQ_W-1:0]  req_type_i,
  input  wire logic [NODE_W-1:0] row_index_i,
  input  wire logic [NODE_W-1:0] col_index_i,
  input  wire logic              rsp_valid_i,
  input  wire logic              rsp_ready_i,
  input  wire logic [1:0]        status_i,
  input  wire logic              edge_present_i,
  input  wire logic [NODE_W-1:0] new_index_i,
  input  wire logic [ROW_W-1:0]  row_bits_i,
  input  wire logic [CNT_W-1:0]  total_nodes_i,
  input  wire logic [CNT_W-1:0]  used_nodes_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o,
  output int unsigned            checked_o,
  output int unsigned            rejects_o,
  output int unsigned            full_hits_o,
  output logic [CNT_W-1:0]       node_total_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NodeCap = (MaxNodes < 64) ? MaxNodes : 64;

  typedef struct packed {
    logic [1:0]        status;
    logic              edge_present;
    logic [NODE_W-1:0] new_index;
    logic [ROW_W-1:0]  row_bits;
    logic [CNT_W-1:0]  total_nodes;
    logic [CNT_W-1:0]  used_nodes;
  } graph_rsp_t;

  // Shadow copy of the graph store.
  logic [ROW_W-1:0] adj_rows [64];
  logic [CNT_W-1:0] node_total;
  logic [ROW_W-1:0] freed_map;

  graph_rsp_t owed_rsp_q[$];

  function automatic logic [1:0] index_status(logic [NODE_W-1:0] idx);
    if ({1'b0, idx} >= node_total) return ST_RANGE;
    if (freed_map[idx]) return ST_UNUSED;
    return ST_OK;
  endfunction

  // Applies one request to the shadow store and returns the response it owes.
  function automatic graph_rsp_t resolve_request(logic [REQ_W-1:0] kind,
                                                 logic [NODE_W-1:0] src,
                                                 logic [NODE_W-1:0] dst);
    graph_rsp_t rsp;
    int unsigned slot;
    rsp = '0;
    case (kind)
      REQ_ADD, REQ_REMOVE, REQ_REPORT: begin
        rsp.status = index_status(src);
        if (rsp.status == ST_OK) rsp.status = index_status(dst);
        if (rsp.status == ST_OK) begin
          if (kind == REQ_ADD) adj_rows[src][dst] = 1'b1;
          else if (kind == REQ_REMOVE) adj_rows[src][dst] = 1'b0;
          else rsp.edge_present = adj_rows[src][dst];
        end
      end
      REQ_INSERT: begin
        if (freed_map != '0) begin
          slot = 0;
          while (!freed_map[slot]) slot++;
          rsp.new_index = NODE_W'(slot);
          freed_map[slot] = 1'b0;
        end else if (node_total < NodeCap) begin
          rsp.new_index = node_total[NODE_W-1:0];
          adj_rows[rsp.new_index] = '0;
          node_total = node_total + 1'b1;
        end else begin
          rsp.status = ST_FULL;
        end
      end
      REQ_DELETE: begin
        rsp.status = index_status(src);
        if (rsp.status == ST_OK) begin
          adj_rows[src] = '0;
          for (int r = 0; r < 64; r++) adj_rows[r][src] = 1'b0;
          freed_map[src] = 1'b1;
        end
      end
      REQ_NEIGH: begin
        rsp.status = index_status(src);
        if (rsp.status == ST_OK) rsp.row_bits = adj_rows[src];
      end
      default: ;
    endcase
    rsp.total_nodes = node_total;
    rsp.used_nodes = node_total - CNT_W'($countones(freed_map));
    return rsp;
  endfunction

  function automatic bit field_differs(string field, logic [ROW_W-1:0] want_v,
                                       logic [ROW_W-1:0] got_v);
    if (got_v === want_v) return 1'b0;
    $error("%s: expected 0x%0h, actual 0x%0h", field, want_v, got_v);
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    graph_rsp_t want;
    if (!rst_ni) begin
      for (int r = 0; r < 64; r++) adj_rows[r] = '0;
      node_total = '0;
      freed_map = '0;
      owed_rsp_q.delete();
      fail_count_o = 0;
      checked_o = 0;
      rejects_o = 0;
      full_hits_o = 0;
    end else begin
      // A response leaving at this edge always belongs to an older request.
      if (rsp_valid_i && rsp_ready_i) begin
        if (owed_rsp_q.size() == 0) begin
          $error("response transfer with no request outstanding");
          fail_count_o++;
        end else begin
          want = owed_rsp_q.pop_front();
          fail_count_o += field_differs("status", want.status, status_i);
          fail_count_o += field_differs("edge_present", want.edge_present, edge_present_i);
          fail_count_o += field_differs("new_index", want.new_index, new_index_i);
          fail_count_o += field_differs("row_bits", want.row_bits, row_bits_i);
          fail_count_o += field_differs("total_nodes", want.total_nodes, total_nodes_i);
          fail_count_o += field_differs("used_nodes", want.used_nodes, used_nodes_i);
          checked_o++;
          if (want.status == ST_FULL) full_hits_o++;
          else if (want.status != ST_OK) rejects_o++;
        end
      end
      // Each accepted request owes one response, queued at the tail in order.
      if (req_valid_i && req_ready_i) begin
        owed_rsp_q.insert(owed_rsp_q.size(),
                          resolve_request(req_type_i, row_index_i, col_index_i));
      end
    end
    pending_o = owed_rsp_q.size();
    node_total_o = node_total;
  end

endmodule

`default_nettype wire

[tb/dynamic_adjacency_bit_matrix_test.sv]
`default_nettype none

module dynamic_adjacency_bit_matrix_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dab_pkg::*;

  // Request types outside the defined set; the block must answer them with
  // an ok status and leave the graph alone.
  localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd7;

  // Length of the deliberate receiver hold-off, in clock cycles.
  localparam int unsigned LongStallCycles = 60;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              req_valid_i;
  logic              req_ready_o;
  logic [REQ_W-1:0]  req_type_i;
  logic [NODE_W-1:0] row_index_i;
  logic [NODE_W-1:0] col_index_i;
  logic              rsp_valid_o;
  logic              rsp_ready_i;
  logic [1:0]        status_o;
  logic              edge_present_o;
  logic [NODE_W-1:0] new_index_o;
  logic [ROW_W-1:0]  row_bits_o;
  logic [CNT_W-1:0]  total_nodes_o;
  logic [CNT_W-1:0]  used_nodes_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned rejects;
  int unsigned full_hits;
  logic [CNT_W-1:0] nodes_now;

  // Percentages of cycles in which each side holds back; changed between
  // phases with nonblocking writes so the other process sees a clean update.
  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 87;
  logic long_stall_q = 1'b0;
  int unsigned sent_count = 0;

  dynamic_adjacency_bit_matrix u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_valid_i),
    .req_ready_o   (req_ready_o),
    .req_type_i    (req_type_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .rsp_valid_o   (rsp_valid_o),
    .rsp_ready_i   (rsp_ready_i),
    .status_o      (status_o),
    .edge_present_o(edge_present_o),
    .new_index_o   (new_index_o),
    .row_bits_o    (row_bits_o),
    .total_nodes_o (total_nodes_o),
    .used_nodes_o  (used_nodes_o)
  );

  // The checker watches both channels, keeps its own copy of the graph and
  // compares every response; the top only drives traffic and reads counts.
  dab_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_valid_i),
    .req_ready_i   (req_ready_o),
    .req_type_i    (req_type_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .rsp_valid_i   (rsp_valid_o),
    .rsp_ready_i   (rsp_ready_i),
    .status_i      (status_o),
    .edge_present_i(edge_present_o),
    .new_index_i   (new_index_o),
    .row_bits_i    (row_bits_o),
    .total_nodes_i (total_nodes_o),
    .used_nodes_i  (used_nodes_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked),
    .rejects_o     (rejects),
    .full_hits_o   (full_hits),
    .node_total_o  (nodes_now)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case the handshake ever locks up.
  initial begin
    #2_000_000;
    $display("Timeout: the run did not complete.");
    $display("*** FAILED ***");
    $finish;
  end

  // Response side. It normally drops ready at random; on request it holds
  // ready low for a long stretch so the block backs up into the request side.
  initial begin
    rsp_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_stall_q) begin
        rsp_ready_i <= 1'b0;
        repeat (LongStallCycles) @(negedge clk_i);
        long_stall_q <= 1'b0;
      end else begin
        rsp_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one request and returns at the falling edge after its transfer.
  // Valid is only lowered when a gap is inserted, so it is never dropped and
  // raised in the same time step between back-to-back requests.
  task automatic send_req(input logic [REQ_W-1:0] kind, input logic [NODE_W-1:0] row,
                          input logic [NODE_W-1:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_type_i <= kind;
    row_index_i <= row;
    col_index_i <= col;
    do @(posedge clk_i); while (!req_ready_o);
    sent_count++;
    @(negedge clk_i);
  endtask

  // Most indices name an allocated node so that requests get past the
  // range check; the rest roam over the whole field.
  function automatic logic [NODE_W-1:0] pick_index();
    if (nodes_now != 0 && $urandom_range(99) < 85) begin
      return NODE_W'($urandom_range(nodes_now - 1));
    end
    return NODE_W'($urandom_range(63));
  endfunction

  task automatic send_random(input int unsigned insert_pct);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < insert_pct) begin
      // The index fields are don't-care for an insert, so fill them with noise.
      send_req(REQ_INSERT, NODE_W'($urandom_range(63)), NODE_W'($urandom_range(63)));
    end else begin
      roll = $urandom_range(99);
      if (roll < 30) send_req(REQ_ADD, pick_index(), pick_index());
      else if (roll < 42) send_req(REQ_REMOVE, pick_index(), pick_index());
      else if (roll < 60) send_req(REQ_REPORT, pick_index(), pick_index());
      else if (roll < 72) send_req(REQ_DELETE, pick_index(), pick_index());
      else if (roll < 92) send_req(REQ_NEIGH, pick_index(), pick_index());
      else send_req(REQ_W'($urandom_range(7)), NODE_W'($urandom_range(63)),
                    NODE_W'($urandom_range(63)));
    end
  endtask

  // Stops offering requests until every outstanding response has come back.
  task automatic drain_responses();
    req_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_type_i = REQ_ADD;
    row_index_i = '0;
    col_index_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. On the empty graph every index is out of range, and
    // the two undefined request types must be ignored.
    send_req(REQ_NEIGH, 6'd0, 6'd0);
    send_req(REQ_ADD, 6'd63, 6'd63);
    send_req(REQ_DELETE, 6'd0, 6'd0);
    send_req(REQ_RSVD_A, 6'd0, 6'd0);
    send_req(REQ_RSVD_B, 6'd63, 6'd63);
    // Build nodes 0 to 3 and exercise edges, including a self loop.
    repeat (4) send_req(REQ_INSERT, 6'd0, 6'd0);
    send_req(REQ_ADD, 6'd0, 6'd3);
    send_req(REQ_ADD, 6'd3, 6'd0);
    send_req(REQ_ADD, 6'd2, 6'd2);
    send_req(REQ_REPORT, 6'd0, 6'd3);
    send_req(REQ_REMOVE, 6'd0, 6'd3);
    send_req(REQ_REPORT, 6'd0, 6'd3);
    send_req(REQ_NEIGH, 6'd3, 6'd0);
    // Range check on the destination, then on the source.
    send_req(REQ_ADD, 6'd0, 6'd9);
    send_req(REQ_ADD, 6'd9, 6'd0);
    // Deleting node 1 must clear the edge 2 to 1 from the column of node 1.
    send_req(REQ_ADD, 6'd2, 6'd1);
    send_req(REQ_DELETE, 6'd1, 6'd0);
    send_req(REQ_NEIGH, 6'd2, 6'd0);
    // A freed index is refused as a source, as a destination, for a second
    // delete, and then handed out again by the next insert with a clean row.
    send_req(REQ_ADD, 6'd1, 6'd0);
    send_req(REQ_REPORT, 6'd0, 6'd1);
    send_req(REQ_DELETE, 6'd1, 6'd0);
    send_req(REQ_INSERT, 6'd0, 6'd0);
    send_req(REQ_NEIGH, 6'd1, 6'd0);

    // Phase one: insert-heavy traffic until the node store is full, so that
    // inserts past capacity are refused and the top indices come into play.
    for (int n = 0; n < 70; n++) begin
      send_req(REQ_INSERT, NODE_W'($urandom_range(63)), NODE_W'($urandom_range(63)));
      if (n % 3 == 2) send_random(10);
    end
    repeat (40) send_random(10);

    // Phase two: the idling of the two sides swaps. A burst of deletes
    // leaves several indices free at once, so the inserts after it show
    // whether the lowest free index is always handed out first.
    drain_responses();
    send_idle_pct <= 87;
    recv_idle_pct <= 38;
    @(negedge clk_i);
    repeat (10) send_req(REQ_DELETE, pick_index(), NODE_W'($urandom_range(63)));
    repeat (10) send_req(REQ_INSERT, NODE_W'($urandom_range(63)), NODE_W'($urandom_range(63)));
    repeat (110) send_random(15);

    // Phase three: neither side idles, except for one long hold-off of the
    // response side while requests keep coming back to back, and one pause
    // of the request side until the block has emptied.
    drain_responses();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    @(negedge clk_i);
    repeat (40) send_random(15);
    long_stall_q <= 1'b1;
    repeat (16) send_random(15);
    drain_responses();
    @(negedge clk_i);
    repeat (60) send_random(15);

    drain_responses();
    repeat (10) @(negedge clk_i);

    $display("Sent %0d requests over three idling patterns; %0d responses checked.",
             sent_count, checked);
    $display("Of those, %0d were index rejections and %0d were inserts refused as full.",
             rejects, full_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
